@@ rtl/core/nfps_pkg.sv @@
`default_nettype none

package nfps_pkg;

    // Field widths.
    localparam int COORD_W   = 16;
    localparam int IDX_W     = 16;
    localparam int DIST_W    = 2 * COORD_W + 1;
    localparam int ROOT_W    = COORD_W + 1;

    // Defaults for the top-level parameters and internal sizes.
    localparam int MAX_POINTS_DEF = 65536;
    localparam int FIFO_DEPTH     = 4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR   = 2'd2;

    // One input point.
    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      last;
    } t_in;

    // One result.
    typedef struct packed {
        logic        [IDX_W-1:0]   best_index;
        logic signed [COORD_W-1:0] best_x;
        logic signed [COORD_W-1:0] best_y;
        logic        [DIST_W-1:0]  dist_sq;
        logic        [ROOT_W-1:0]  dist_root;
    } t_out;

    // A classified point on its way from the front to the back.
    typedef struct packed {
        logic        [DIST_W-1:0]  sq_dist;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      last;
    } t_cand;

    // Status of the square root unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_sq_stat;

endpackage

`default_nettype wire

@@ rtl/core/nfps_fifo.sv @@
`default_nettype none

module nfps_fifo #(
    parameter int DEPTH = nfps_pkg::FIFO_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  nfps_pkg::t_cand     i_data,
    output logic                o_full,
    input  wire                 i_pop,
    output nfps_pkg::t_cand     o_data,
    output logic                o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nfps_pkg::t_cand r_mem [DEPTH];

    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage is written at the write pointer.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers wrap at the depth; the count tracks occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/nfps_isqrt.sv @@
`default_nettype none

module nfps_isqrt (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    input  wire  [nfps_pkg::DIST_W-1:0]        i_radicand,
    input  wire                                i_ack,
    output nfps_pkg::t_sq_stat                 o_stat,
    output logic [nfps_pkg::ROOT_W-1:0]        o_root
);

    localparam int ROOT_W = nfps_pkg::ROOT_W;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int STEP_W = $clog2(ROOT_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    logic              fits;

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;

    // One result bit per cycle: bring down two radicand bits and try a subtract.
    always_comb begin
        cur   = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial = {r_root[ROOT_W-2:0], 2'b01};
        fits  = (cur >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start && !r_busy && !r_done) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (r_done && i_ack) begin
                r_done <= 1'b0;
            end
        end
    end

    // Datapath for the iteration.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy && !r_done) begin
            r_rad  <= RAD_W'(i_radicand);
            r_rem  <= '0;
            r_root <= '0;
            r_step <= STEP_W'(ROOT_W - 1);
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= fits ? (cur - trial) : cur;
            r_root <= {r_root[ROOT_W-2:0], fits};
            r_step <= r_step - 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/nfps_front.sv @@
`default_nettype none

module nfps_front (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 push,
    output logic                                full,
    input  nfps_pkg::t_in                       i_in,
    input  wire  signed [nfps_pkg::COORD_W-1:0] i_ref_x,
    input  wire  signed [nfps_pkg::COORD_W-1:0] i_ref_y,
    output logic                                o_push,
    output nfps_pkg::t_cand                     o_cand,
    input  wire                                 i_fifo_full
);

    localparam int COORD_W = nfps_pkg::COORD_W;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = nfps_pkg::DIST_W;

    logic en;

    logic                      r_v1;
    logic [COORD_W-1:0]        r_dx;
    logic [COORD_W-1:0]        r_dy;
    logic signed [COORD_W-1:0] r_x1;
    logic signed [COORD_W-1:0] r_y1;
    logic                      r_l1;

    logic                      r_v2;
    logic [SQ_W-1:0]           r_sqx;
    logic [SQ_W-1:0]           r_sqy;
    logic signed [COORD_W-1:0] r_x2;
    logic signed [COORD_W-1:0] r_y2;
    logic                      r_l2;

    logic                      r_v3;
    nfps_pkg::t_cand           r_cand;

    logic signed [DIFF_W-1:0]  diff_x;
    logic signed [DIFF_W-1:0]  diff_y;
    logic [DIFF_W-1:0]         abs_x;
    logic [DIFF_W-1:0]         abs_y;

    // The whole pipe moves unless the last stage is stuck on a full queue.
    assign en     = !r_v3 || !i_fifo_full;
    assign full   = !en;
    assign o_push = r_v3 && !i_fifo_full;
    assign o_cand = r_cand;

    // Absolute coordinate differences to the reference point.
    always_comb begin
        diff_x = {i_in.px[COORD_W-1], i_in.px} - {i_ref_x[COORD_W-1], i_ref_x};
        diff_y = {i_in.py[COORD_W-1], i_in.py} - {i_ref_y[COORD_W-1], i_ref_y};
        abs_x  = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
        abs_y  = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Differences, then squares, then their sum.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx <= abs_x[COORD_W-1:0];
            r_dy <= abs_y[COORD_W-1:0];
            r_x1 <= i_in.px;
            r_y1 <= i_in.py;
            r_l1 <= i_in.last;

            r_sqx <= r_dx * r_dx;
            r_sqy <= r_dy * r_dy;
            r_x2  <= r_x1;
            r_y2  <= r_y1;
            r_l2  <= r_l1;

            r_cand.sq_dist <= DIST_W'(r_sqx) + DIST_W'(r_sqy);
            r_cand.px      <= r_x2;
            r_cand.py      <= r_y2;
            r_cand.last    <= r_l2;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/nfps_back.sv @@
`default_nettype none

module nfps_back #(
    parameter int MAX_POINTS = nfps_pkg::MAX_POINTS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  nfps_pkg::t_cand  i_cand,
    input  wire              i_fifo_empty,
    output logic             o_pop,
    input  wire              i_far,
    output logic             empty,
    input  wire              pop,
    output nfps_pkg::t_out   o_out
);

    localparam int CNT_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int COORD_W = nfps_pkg::COORD_W;
    localparam int IDX_W   = nfps_pkg::IDX_W;
    localparam int DIST_W  = nfps_pkg::DIST_W;
    localparam int ROOT_W  = nfps_pkg::ROOT_W;

    // Running best of the current set.
    logic                      r_have;
    logic [CNT_W-1:0]          r_count;
    logic [DIST_W-1:0]         r_best_sq;
    logic [IDX_W-1:0]          r_best_idx;
    logic signed [COORD_W-1:0] r_best_x;
    logic signed [COORD_W-1:0] r_best_y;

    // Winner of a finished set while its root is worked out.
    logic [DIST_W-1:0]         r_win_sq;
    logic [IDX_W-1:0]          r_win_idx;
    logic signed [COORD_W-1:0] r_win_x;
    logic signed [COORD_W-1:0] r_win_y;

    logic                      r_out_v;
    nfps_pkg::t_out            r_out;

    nfps_pkg::t_sq_stat        sq_stat;
    logic [ROOT_W-1:0]         sq_root;
    logic                      sq_idle;
    logic                      take;
    logic                      start;
    logic                      load_out;
    logic [DIST_W-1:0]         win_sq;
    logic [IDX_W-1:0]          cur_idx;

    assign sq_idle  = !sq_stat.busy && !sq_stat.done;
    assign o_pop    = !i_fifo_empty && (!i_cand.last || sq_idle);
    assign start    = o_pop && i_cand.last;
    assign load_out = sq_stat.done && (!r_out_v || pop);
    assign empty    = !r_out_v;
    assign o_out    = r_out;
    assign cur_idx  = IDX_W'(r_count);
    assign win_sq   = take ? i_cand.sq_dist : r_best_sq;

    // The first point of a set always wins; ties keep the earlier point.
    always_comb begin
        if (!r_have) begin
            take = 1'b1;
        end else if (i_far) begin
            take = (i_cand.sq_dist > r_best_sq);
        end else begin
            take = (i_cand.sq_dist < r_best_sq);
        end
    end

    // Set bookkeeping and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_count <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_cand.last) begin
                    r_have  <= 1'b0;
                    r_count <= '0;
                end else begin
                    r_have  <= 1'b1;
                    r_count <= (r_count == CNT_W'(MAX_POINTS - 1)) ? '0 : r_count + 1'b1;
                end
            end
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Best-so-far, winner hand-off and result register.
    always_ff @(posedge i_clk) begin
        if (o_pop && take && !i_cand.last) begin
            r_best_sq  <= i_cand.sq_dist;
            r_best_idx <= cur_idx;
            r_best_x   <= i_cand.px;
            r_best_y   <= i_cand.py;
        end
        if (start) begin
            r_win_sq  <= win_sq;
            r_win_idx <= take ? cur_idx : r_best_idx;
            r_win_x   <= take ? i_cand.px : r_best_x;
            r_win_y   <= take ? i_cand.py : r_best_y;
        end
        if (load_out) begin
            r_out.best_index <= r_win_idx;
            r_out.best_x     <= r_win_x;
            r_out.best_y     <= r_win_y;
            r_out.dist_sq    <= r_win_sq;
            r_out.dist_root  <= sq_root;
        end
    end

    nfps_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_radicand (win_sq),
        .i_ack      (load_out),
        .o_stat     (sq_stat),
        .o_root     (sq_root)
    );

endmodule

`default_nettype wire

@@ rtl/core/nearest_farthest_point_search.sv @@
// Path: a last point passes the 3 distance stages, then the queue, the set update,
// 17 root iterations and the result register before its result shows on the output.
// Throughput: one point per cycle while the queue is not full; the bit-serial square root
// limits how often sets can finish, as a last point waits in the queue until the root unit is idle.
// Reset: synchronous, active low; clears the pipe, queue, set state and configuration to zero.
`default_nettype none

module nearest_farthest_point_search #(
    parameter int MAX_POINTS = nfps_pkg::MAX_POINTS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   push,
    output logic                                  full,
    input  nfps_pkg::t_in                         i_in,
    output logic                                  empty,
    input  wire                                   pop,
    output nfps_pkg::t_out                        o_out,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [nfps_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [nfps_pkg::COORD_W-1:0]          i_cfg_data
);

    logic signed [nfps_pkg::COORD_W-1:0] r_ref_x;
    logic signed [nfps_pkg::COORD_W-1:0] r_ref_y;
    logic                                r_far;

    logic            f_push;
    logic            f_full;
    logic            f_pop;
    logic            f_empty;
    nfps_pkg::t_cand f_wdata;
    nfps_pkg::t_cand f_rdata;

    assign o_cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= '0;
            r_ref_y <= '0;
            r_far   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                nfps_pkg::CFG_REF_X: r_ref_x <= i_cfg_data;
                nfps_pkg::CFG_REF_Y: r_ref_y <= i_cfg_data;
                nfps_pkg::CFG_FAR:   r_far   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    nfps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .i_ref_x     (r_ref_x),
        .i_ref_y     (r_ref_y),
        .o_push      (f_push),
        .o_cand      (f_wdata),
        .i_fifo_full (f_full)
    );

    nfps_fifo #(
        .DEPTH (nfps_pkg::FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_wdata),
        .o_full  (f_full),
        .i_pop   (f_pop),
        .o_data  (f_rdata),
        .o_empty (f_empty)
    );

    nfps_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cand       (f_rdata),
        .i_fifo_empty (f_empty),
        .o_pop        (f_pop),
        .i_far        (r_far),
        .empty        (empty),
        .pop          (pop),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import nfps_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int STALL_CYCLES    = 400;
    localparam int REPORT_LIMIT    = 10;
    localparam int RANDOM_POINTS   = 2000;
    localparam int RANDOM_PHASES   = 10;
    localparam int LONG_SET_POINTS = 100;
    localparam int LONG_SET_WINNER = 97;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 full;
    t_in                  i_in        = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    t_out                 o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COORD_W-1:0]   i_cfg_data  = '0;

    // Search settings as the block should hold them.
    logic signed [COORD_W-1:0] ref_x_q;
    logic signed [COORD_W-1:0] ref_y_q;
    logic                      farthest_q;

    // Running best of the current set.
    longint                    best_sq_q;
    logic [IDX_W-1:0]          best_idx_q;
    logic signed [COORD_W-1:0] best_x_q;
    logic signed [COORD_W-1:0] best_y_q;
    logic [IDX_W-1:0]          point_pos_q;
    logic                      have_best_q;

    // Winners of completed sets, oldest first.
    t_out winners_due[$];

    int   tx_gap_max  = 0;
    int   rx_gap_max  = 0;
    int   rx_wait     = 0;
    int   mismatches  = 0;
    int   cycle_count = 0;
    logic rx_hold     = 1'b0;
    event rx_stall_go;

    nearest_farthest_point_search dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [ROOT_W-1:0] floor_root(longint sq);
        longint root;
        longint trial;
        root = 0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= sq) begin
                root = trial;
            end
        end
        return root[ROOT_W-1:0];
    endfunction

    function automatic void clear_set();
        best_sq_q   = 0;
        best_idx_q  = '0;
        best_x_q    = '0;
        best_y_q    = '0;
        point_pos_q = '0;
        have_best_q = 1'b0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
        case (idx)
            CFG_REF_X: begin
                ref_x_q = data;
            end
            CFG_REF_Y: begin
                ref_y_q = data;
            end
            CFG_FAR: begin
                farthest_q = data[0];
            end
            default: begin
            end
        endcase
    endfunction

    // Fold one accepted point into the running best; a marked point closes the set.
    function automatic void search_update(t_in p);
        longint dx;
        longint dy;
        longint d;
        logic   take;
        t_out   w;
        dx = longint'($signed(p.px)) - longint'(ref_x_q);
        dy = longint'($signed(p.py)) - longint'(ref_y_q);
        d  = dx * dx + dy * dy;
        // The first point of a set always wins; ties keep the earlier point.
        take = !have_best_q || (farthest_q ? (d > best_sq_q) : (d < best_sq_q));
        if (take) begin
            best_sq_q   = d;
            best_idx_q  = point_pos_q;
            best_x_q    = p.px;
            best_y_q    = p.py;
            have_best_q = 1'b1;
        end
        // The position wraps to zero after MAX_POINTS-1, which is the 16-bit range.
        point_pos_q = point_pos_q + 1'b1;
        if (p.last) begin
            w.best_index = best_idx_q;
            w.best_x     = best_x_q;
            w.best_y     = best_y_q;
            w.dist_sq    = best_sq_q[DIST_W-1:0];
            w.dist_root  = floor_root(best_sq_q);
            winners_due.push_back(w);
            clear_set();
        end
    endfunction

    function automatic void check_winner(t_out got);
        t_out want;
        if (winners_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("ERROR: result with none pending: index %0d x %0d y %0d sq %0d root %0d",
                         got.best_index, $signed(got.best_x), $signed(got.best_y),
                         got.dist_sq, got.dist_root);
            end
            return;
        end
        want = winners_due.pop_front();
        if (got.best_index !== want.best_index || got.best_x !== want.best_x ||
            got.best_y !== want.best_y || got.dist_sq !== want.dist_sq ||
            got.dist_root !== want.dist_root) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("MISMATCH (expected/actual): index %0d/%0d x %0d/%0d y %0d/%0d",
                         want.best_index, got.best_index,
                         $signed(want.best_x), $signed(got.best_x),
                         $signed(want.best_y), $signed(got.best_y));
                $display("  sq %0d/%0d root %0d/%0d",
                         want.dist_sq, got.dist_sq, want.dist_root, got.dist_root);
            end
        end
    endfunction

    // Result side: check each transfer, then wait a drawn number of cycles before popping again.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_wait = 0;
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                check_winner(o_out);
                rx_wait = $urandom_range(0, rx_gap_max);
            end else if (rx_wait > 0) begin
                rx_wait = rx_wait - 1;
            end
            pop <= (rx_wait == 0) && !rx_hold;
        end
    end

    // Long hold-off of the result side, counted here so the sender keeps going.
    initial begin
        forever begin
            @(rx_stall_go);
            rx_hold <= 1'b1;
            repeat (STALL_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    // Valid stays high from one register to the next; the caller lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    // Upper bits of the mode word and the spare register get random values.
    task automatic set_search(input logic [COORD_W-1:0] ref_x_new,
                              input logic [COORD_W-1:0] ref_y_new, input logic far_new);
        logic [COORD_W-2:0] noise;
        noise = $urandom;
        write_reg(CFG_REF_X, ref_x_new);
        write_reg(CFG_REF_Y, ref_y_new);
        write_reg(CFG_FAR, {noise, far_new});
        write_reg(CFG_SPARE, $urandom);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Push stays high after a transfer so that back-to-back points need no second assignment.
    task automatic offer_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic last);
        t_in p;
        int  gap;
        p.px = x;
        p.py = y;
        p.last = last;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= p;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        search_update(p);
    endtask

    // Wait for every pending winner, then let the pipe empty of unmarked points.
    task automatic settle();
        push <= 1'b0;
        while (winners_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_field_extremes();
        tx_gap_max = 0;
        rx_gap_max = 0;
        // Reset settings: reference at the origin, nearest mode.
        offer_point(16'h0000, 16'h0000, 1'b1);
        offer_point(16'h8000, 16'h8000, 1'b1);
        offer_point(16'h7fff, 16'h8000, 1'b1);
        settle();
        set_search(16'h7fff, 16'h7fff, 1'b0);
        offer_point(16'h8000, 16'h8000, 1'b1);
        offer_point(16'h7fff, 16'h7fff, 1'b1);
        settle();
        set_search(16'h8000, 16'h8000, 1'b1);
        offer_point(16'h7fff, 16'h7fff, 1'b1);
        offer_point(16'h7fff, 16'h8000, 1'b1);
    endtask

    task automatic test_first_point();
        settle();
        // Farthest mode: a zero-distance opener still wins, and equal points do not replace it.
        set_search(16'h0000, 16'h0000, 1'b1);
        offer_point(16'h0000, 16'h0000, 1'b0);
        offer_point(16'h0000, 16'h0000, 1'b0);
        offer_point(16'h0000, 16'h0000, 1'b1);
        settle();
        // Nearest mode: a far opener is replaced, and a later tie keeps the earlier point.
        set_search(16'd100, -16'sd100, 1'b0);
        offer_point(16'h7fff, 16'h7fff, 1'b0);
        offer_point(16'd101, -16'sd100, 1'b0);
        offer_point(16'd99, -16'sd100, 1'b1);
    endtask

    task automatic test_config_mid_set();
        settle();
        set_search(16'h0000, 16'h0000, 1'b0);
        offer_point(16'd10, 16'd0, 1'b0);
        offer_point(16'd5, 16'd0, 1'b0);
        settle();
        // New reference and mode apply to the rest of the set only.
        set_search(16'd5, 16'd0, 1'b1);
        offer_point(16'd6, 16'd0, 1'b0);
        offer_point(-16'sd30, 16'd0, 1'b1);
    endtask

    task automatic test_long_set();
        settle();
        set_search(16'h0000, 16'h0000, 1'b0);
        tx_gap_max = 0;
        rx_gap_max = 0;
        // Only one point sits on the reference, late in a set much longer than the pipe.
        for (int i = 0; i < LONG_SET_POINTS; i++) begin
            if (i == LONG_SET_WINNER) begin
                offer_point(16'h0000, 16'h0000, 1'b0);
            end else begin
                offer_point($urandom_range(1, 32767), $urandom, i == LONG_SET_POINTS - 1);
            end
        end
    endtask

    task automatic test_output_backpressure();
        int len;
        settle();
        tx_gap_max = 0;
        rx_gap_max = 0;
        -> rx_stall_go;
        for (int s = 0; s < 60; s++) begin
            len = $urandom_range(1, 2);
            for (int i = 0; i < len; i++) begin
                offer_point($urandom, $urandom, i == len - 1);
            end
        end
    endtask

    task automatic test_random_sets();
        int                 sent;
        int                 len;
        int                 kind;
        int                 off_x;
        int                 off_y;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] prev_x;
        logic [COORD_W-1:0] prev_y;
        prev_x = '0;
        prev_y = '0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            case (ph)
                0: set_search(16'h8000, 16'h7fff, 1'b0);
                1: set_search(16'h7fff, 16'h8000, 1'b1);
                2: set_search(16'h0000, 16'h0000, $urandom_range(0, 1));
                default: set_search($urandom, $urandom, $urandom_range(0, 1));
            endcase
            // Some phases run without any idling on one side or both.
            case ($urandom_range(0, 2))
                0: tx_gap_max = 0;
                1: tx_gap_max = 3;
                default: tx_gap_max = 14;
            endcase
            case ($urandom_range(0, 2))
                0: rx_gap_max = 0;
                1: rx_gap_max = 3;
                default: rx_gap_max = 14;
            endcase
            sent = 0;
            while (sent < RANDOM_POINTS / RANDOM_PHASES) begin
                kind = $urandom_range(0, 19);
                if (kind < 16) begin
                    len = $urandom_range(1, 8);
                end else if (kind < 19) begin
                    len = $urandom_range(9, 40);
                end else begin
                    len = $urandom_range(41, 150);
                end
                for (int i = 0; i < len; i++) begin
                    kind = $urandom_range(0, 9);
                    if (kind < 4) begin
                        x = $urandom;
                        y = $urandom;
                    end else if (kind < 8) begin
                        // Close to the reference, where equal distances are common.
                        off_x = int'($urandom_range(0, 8)) - 4;
                        off_y = int'($urandom_range(0, 8)) - 4;
                        x = ref_x_q + off_x[COORD_W-1:0];
                        y = ref_y_q + off_y[COORD_W-1:0];
                    end else begin
                        x = prev_x;
                        y = prev_y;
                    end
                    offer_point(x, y, i == len - 1);
                    prev_x = x;
                    prev_y = y;
                end
                sent += len;
            end
        end
    endtask

    initial begin
        ref_x_q    = '0;
        ref_y_q    = '0;
        farthest_q = 1'b0;
        clear_set();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_first_point();
        test_config_mid_set();
        test_output_backpressure();
        test_long_set();
        test_random_sets();
        settle();

        if (mismatches == 0 && winners_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
